### hw/rtl/dcs_pkg.sv
// ============================================================================
// dcs_pkg: shared definitions for the distinct count sketch
// Holds the sketch constants, the hash round, the estimate table and the
// controller/datapath command and status types.
// ============================================================================
package dcs_pkg;

    // Sketch bitmap width
    localparam int MAP_BITS = 12;
    // Bits needed to hold a run length of 0..MAP_BITS
    localparam int RUN_W    = $clog2(MAP_BITS + 1);

    // Field widths
    localparam int ITEM_W   = 32;
    localparam int FZ_W     = 4;
    localparam int EST_W    = 13;
    localparam int OUT_W    = FZ_W + EST_W;
    localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;

    // Hash multiplier and the 0.77351 correction held as a ratio
    localparam logic [31:0] HASH_MUL = 32'h119d_e1f3;
    localparam logic [63:0] PHI_NUM  = 64'd77351;
    localparam logic [63:0] PHI_DEN  = 64'd100000;

    typedef logic [EST_W-1:0] t_est_tab [MAP_BITS+1];

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_MARK,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture item and last flag
        logic mix;    // one hash round on the shared multiplier
        logic mark;   // final xor-shift and bitmap update
        logic emit;   // load result register and clear bitmap
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last;      // captured item ends the stream
        logic out_free;  // result register can take a new result
    } t_stat;

    // One hash round: xor-shift by 16, then multiply with 32-bit wrap
    function automatic logic [31:0] mix_round(input logic [31:0] h);
        logic [31:0] x;
        x = h ^ (h >> 16);
        return x * HASH_MUL;
    endfunction

    // floor(2^r / 0.77351) for r = 0..MAP_BITS, masked to the field width
    function automatic t_est_tab build_est_tab();
        t_est_tab   tab;
        logic [63:0] v;
        for (int r = 0; r <= MAP_BITS; r++) begin
            v      = ((64'd1 << r) * PHI_DEN) / PHI_NUM;
            tab[r] = v[EST_W-1:0];
        end
        return tab;
    endfunction

    localparam t_est_tab EST_TAB = build_est_tab();

endpackage

### hw/rtl/dcs_ctrl.sv
// ============================================================================
// dcs_ctrl: sequencer for the distinct count sketch
// Steps each item through capture, two hash rounds, the bitmap mark and,
// on the last item of a stream, the result emit.
// ============================================================================
module dcs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dcs_pkg::t_stat i_stat,
    output dcs_pkg::t_cmd  o_cmd
);

    dcs_pkg::t_state r_state;
    dcs_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dcs_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = dcs_pkg::ST_MIX1;
            end
            dcs_pkg::ST_MIX1: n_state = dcs_pkg::ST_MIX2;
            dcs_pkg::ST_MIX2: n_state = dcs_pkg::ST_MARK;
            dcs_pkg::ST_MARK: begin
                n_state = i_stat.last ? dcs_pkg::ST_EMIT : dcs_pkg::ST_IDLE;
            end
            dcs_pkg::ST_EMIT: begin
                if (i_stat.out_free) n_state = dcs_pkg::ST_IDLE;
            end
            default: n_state = dcs_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            dcs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            dcs_pkg::ST_MIX1: o_cmd.mix  = 1'b1;
            dcs_pkg::ST_MIX2: o_cmd.mix  = 1'b1;
            dcs_pkg::ST_MARK: o_cmd.mark = 1'b1;
            dcs_pkg::ST_EMIT: o_cmd.emit = i_stat.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/dcs_dpath.sv
// ============================================================================
// dcs_dpath: datapath for the distinct count sketch
// Shared hash multiplier, sketch bitmap, run-length encoder, estimate table
// and the result register.
// ============================================================================
module dcs_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dcs_pkg::t_cmd                i_cmd,
    output dcs_pkg::t_stat               o_stat,
    input  logic [dcs_pkg::ITEM_W-1:0]   i_item,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [dcs_pkg::FZ_W-1:0]     o_first_zero,
    output logic [dcs_pkg::EST_W-1:0]    o_estimate
);

    logic [31:0]                   r_hash;
    logic                          r_last;
    logic [dcs_pkg::MAP_BITS-1:0]  r_seen;
    logic                          r_out_valid;
    logic [dcs_pkg::FZ_W-1:0]      r_fz;
    logic [dcs_pkg::EST_W-1:0]     r_est;

    logic [31:0]                   hash_fin;
    logic [dcs_pkg::MAP_BITS-2:0]  low_bits;
    logic [dcs_pkg::MAP_BITS-2:0]  low_iso;
    logic [dcs_pkg::MAP_BITS-1:0]  slot_oh;
    logic [dcs_pkg::MAP_BITS:0]    seen_ext;
    logic [dcs_pkg::MAP_BITS:0]    zero_oh;
    logic [dcs_pkg::RUN_W-1:0]     run;
    logic                          out_free;

    // Slot select: lowest set bit below the top slot, top slot otherwise
    assign hash_fin = r_hash ^ (r_hash >> 16);
    assign low_bits = hash_fin[dcs_pkg::MAP_BITS-2:0];
    assign low_iso  = low_bits & (~low_bits + 1'b1);
    assign slot_oh  = {(low_bits == '0), low_iso};

    // Run of set bits from bit 0: isolate the first clear bit, then encode
    assign seen_ext = {1'b0, r_seen};
    assign zero_oh  = ~seen_ext & (seen_ext + 1'b1);

    always_comb begin
        run = '0;
        for (int i = 0; i <= dcs_pkg::MAP_BITS; i++) begin
            if (zero_oh[i]) run = run | dcs_pkg::RUN_W'(i);
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Item capture and the shared hash round
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hash <= i_item;
            r_last <= i_last;
        end else if (i_cmd.mix) begin
            r_hash <= dcs_pkg::mix_round(r_hash);
        end
    end

    // Sketch bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_cmd.emit) begin
            r_seen <= '0;
        end else if (i_cmd.mark) begin
            r_seen <= r_seen | slot_oh;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_fz  <= dcs_pkg::FZ_W'(run);
            r_est <= dcs_pkg::EST_TAB[run];
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_first_zero    = r_fz;
    assign o_estimate      = r_est;

endmodule

### hw/rtl/distinct_count_sketch_top.sv
// ============================================================================
// distinct_count_sketch_top: Flajolet-Martin distinct count sketch
// Stream in 32-bit items; the item marked tlast closes the stream and
// produces one estimate of the number of distinct items seen.
// ============================================================================
// Each item is hashed (two xor-shift/multiply rounds and a final xor-shift),
// its trailing-zero count picks a bitmap bit, and on the tlast item the run
// of set bits from bit 0 and the matching estimate go out as one result,
// after which the bitmap starts empty again. An ordinary item goes from
// acceptance to the next tready through its capture, two rounds on the single
// shared 32x32 hash multiplier and the bitmap mark. The tlast item then also
// loads the result register, once the previous result no longer waits
// downstream. The result register lets a new stream start while a result
// is pending.
module distinct_count_sketch_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: [31:0] item
    input  logic [dcs_pkg::ITEM_W-1:0]     i_s_axis_tdata,
    input  logic                           i_s_axis_tlast,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: [3:0] first_zero, [16:4] estimate, rest zero
    output logic [dcs_pkg::OUT_TW-1:0]     o_m_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready
);

    dcs_pkg::t_cmd               cmd;
    dcs_pkg::t_stat              stat;
    logic [dcs_pkg::FZ_W-1:0]    first_zero;
    logic [dcs_pkg::EST_W-1:0]   estimate;

    // Sequencer
    dcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Hash, bitmap and result
    dcs_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_item       (i_s_axis_tdata),
        .i_last       (i_s_axis_tlast),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_first_zero (first_zero),
        .o_estimate   (estimate)
    );

    // Output packing
    assign o_m_axis_tdata = dcs_pkg::OUT_TW'({estimate, first_zero});

endmodule

### hw/rtl/dcs_check.sv
// ============================================================================
// dcs_check: port-level checks for the distinct count sketch
// Watches the top-level stream ports and is bound to the top level.
// ============================================================================
module dcs_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tlast,
    input  logic                           i_s_axis_tvalid,
    input  logic                           o_s_axis_tready,
    input  logic [dcs_pkg::OUT_TW-1:0]     o_m_axis_tdata,
    input  logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready
);

    logic s_acc;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // Result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // Busy while an item is hashed
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready ##1 !o_s_axis_tready ##1 !o_s_axis_tready)
        else $error("item taken while the previous one is in work");

    // An ordinary item never creates a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !i_s_axis_tlast && !o_m_axis_tvalid)
            |=> !o_m_axis_tvalid ##1 !o_m_axis_tvalid ##1 !o_m_axis_tvalid)
        else $error("result without a closing item");

    // Result fields stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((dcs_pkg::MAP_BITS > 15) || (o_m_axis_tdata[3:0] <= dcs_pkg::MAP_BITS))
            && (o_m_axis_tdata[16:4] != '0)
            && (o_m_axis_tdata[dcs_pkg::OUT_TW-1:dcs_pkg::OUT_W] == '0))
        else $error("result field out of range");

endmodule

bind distinct_count_sketch_top dcs_check u_dcs_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

### test/testbench.sv
// ============================================================================
// testbench: self-checking bench for distinct_count_sketch_top
// Streams of 32-bit items go in over the slave stream port. A scoreboard keeps
// its own copy of the sketch bitmap, predicts first_zero and the estimate for
// each stream closed by tlast, and checks every result item in order. Both
// stream sides insert random gaps and stalls.
// ============================================================================
module testbench;

    localparam int MAPW = dcs_pkg::MAP_BITS;
    localparam int FZW = dcs_pkg::FZ_W;
    localparam int ESTW = dcs_pkg::EST_W;
    localparam int OUTW = dcs_pkg::OUT_W;
    localparam int OUTTW = dcs_pkg::OUT_TW;
    localparam logic [31:0] MIX_MUL = 32'h119d_e1f3;
    // 1/0.77351 held as an exact ratio
    localparam logic [63:0] RATIO_NUM = 64'd100000;
    localparam logic [63:0] RATIO_DEN = 64'd77351;
    localparam int TARGET_ITEMS = 1650;

    typedef struct {
        logic [FZW-1:0]  run;
        logic [ESTW-1:0] est;
    } t_estimate;

    // Tracks the sketch bitmap and the estimates still owed by the block
    class sketch_scoreboard;
        logic [MAPW-1:0] bitmap;
        t_estimate       owed_q[$];
        int              fails;
        int              items_seen;
        int              streams_seen;
        int              results_seen;
        logic [MAPW:0]   runs_hit;

        function new();
            bitmap = '0;
            fails = 0;
            items_seen = 0;
            streams_seen = 0;
            results_seen = 0;
            runs_hit = '0;
        endfunction

        // Two xor-shift/multiply rounds, then a final xor-shift
        static function logic [31:0] hash_item(logic [31:0] v);
            logic [31:0] h;
            h = v;
            h = (h ^ (h >> 16)) * MIX_MUL;
            h = (h ^ (h >> 16)) * MIX_MUL;
            return h ^ (h >> 16);
        endfunction

        // Trailing-zero count of the hash, clamped to the top bitmap bit
        static function int slot_of(logic [31:0] v);
            logic [31:0] h;
            int i;
            h = hash_item(v);
            i = 0;
            while (i < MAPW - 1 && i < 32 && !h[i])
                i++;
            return i;
        endfunction

        function void note_item(logic [31:0] v, logic last);
            int run;
            logic [63:0] q;
            t_estimate e;
            items_seen++;
            bitmap[slot_of(v)] = 1'b1;
            if (last) begin
                run = 0;
                while (run < MAPW && bitmap[run])
                    run++;
                q = ((64'd1 << run) * RATIO_NUM) / RATIO_DEN;
                e.run = run[FZW-1:0];
                e.est = q[ESTW-1:0];
                owed_q.push_back(e);
                bitmap = '0;
                streams_seen++;
            end
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
            fails++;
        endtask

        task check_result(logic [OUTTW-1:0] d);
            t_estimate e;
            if (owed_q.size() == 0) begin
                report("result item with no closed stream", d, 0);
            end else begin
                e = owed_q.pop_front();
                results_seen++;
                runs_hit[e.run] = 1'b1;
                if (d[FZW-1:0] !== e.run)
                    report("first_zero", d[FZW-1:0], e.run);
                if (d[FZW+ESTW-1:FZW] !== e.est)
                    report("estimate", d[FZW+ESTW-1:FZW], e.est);
                if (d[OUTTW-1:OUTW] !== '0)
                    report("tdata padding", d[OUTTW-1:OUTW], 0);
            end
        endtask

        task drain_check();
            while (owed_q.size() != 0) begin
                report("estimate never delivered", 0, owed_q[0].run);
                void'(owed_q.pop_front());
            end
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic [31:0]       s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [OUTTW-1:0]  m_tdata;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic              tx_quiet = 1'b0;
    logic              rx_quiet = 1'b0;

    sketch_scoreboard board = new();

    distinct_count_sketch_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #12_000_000;
        $display("FAILURE");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Random item whose hash lands on the given bitmap bit
    function automatic logic [31:0] item_for_slot(int slot);
        logic [31:0] v;
        do
            v = $urandom;
        while (sketch_scoreboard::slot_of(v) != slot);
        return v;
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_item(logic [31:0] v, logic last);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata <= v;
        s_tlast <= last;
        s_tvalid <= 1'b1;
        do
            @(posedge i_clk);
        while (!s_tready);
        board.note_item(v, last);
    endtask

    task automatic send_stream(logic [31:0] items[$]);
        foreach (items[i])
            send_item(items[i], i == items.size() - 1);
    endtask

    // Result side: random stalls, checks every accepted result item
    initial begin
        int stall;
        stall = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_quiet) begin
                m_tready <= 1'b1;
                stall = 0;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                stall = pick_gap();
                m_tready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end
            @(posedge i_clk);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
        end
    end

    // Stimulus
    initial begin
        logic [31:0] q[$];
        logic [31:0] tmp;
        int kind;
        int len;
        int k;
        int j;
        int waited;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero item hashes to zero: top bit only, empty run
        q = {32'h0000_0000};
        send_stream(q);
        // All-ones item alone
        q = {32'hffff_ffff};
        send_stream(q);
        // Every bitmap bit set: full run, largest estimate
        q = {};
        for (int s = 0; s < MAPW; s++)
            q.push_back(item_for_slot(s));
        send_stream(q);
        // Bits 0..4, closed by another bit-0 item
        q = {};
        for (int s = 0; s < 5; s++)
            q.push_back(item_for_slot(s));
        q.push_back(item_for_slot(0));
        send_stream(q);
        // Same item three times
        tmp = $urandom;
        q = {tmp, tmp, tmp};
        send_stream(q);

        // Random streams until the item budget is spent
        while (board.items_seen < TARGET_ITEMS) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            q = {};
            if (kind < 6) begin
                // Covers bits 0..k-1 in random order plus some noise and repeats
                k = $urandom_range(0, MAPW);
                for (int s = 0; s < k; s++)
                    q.push_back(item_for_slot(s));
                len = $urandom_range(0, 3);
                for (int i = 0; i < len; i++)
                    q.push_back((q.size() > 0 && $urandom_range(0, 1)) ?
                                q[$urandom_range(0, q.size() - 1)] : $urandom);
                if (q.size() == 0)
                    q.push_back($urandom);
                for (int i = q.size() - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = q[i];
                    q[i] = q[j];
                    q[j] = tmp;
                end
            end else begin
                len = (kind < 9) ? $urandom_range(1, 20) : $urandom_range(30, 80);
                for (int i = 0; i < len; i++)
                    q.push_back((q.size() > 0 && $urandom_range(0, 3) == 0) ?
                                q[$urandom_range(0, q.size() - 1)] : $urandom);
            end
            send_stream(q);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b0;

        // Let the owed estimates drain, then watch for stray results
        waited = 0;
        while (board.owed_q.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);
        board.drain_check();

        $display("ran %0d items in %0d streams, %0d estimates checked",
                 board.items_seen, board.streams_seen, board.results_seen);
        $display("first_zero values reached (bit per value): %b", board.runs_hit);
        if (board.fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
